// ===== sv/mep_pkg.sv =====
// Shared types, constants and helper functions of the escape-time pixel block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mep_pkg;

    localparam int HALF_W    = 31;
    localparam int IDX_W     = 10;
    localparam int LIMIT_W   = 12;
    localparam int COLOR_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_BITS = 28;

    localparam int C_W    = 34;
    localparam int Z_W    = 31;
    localparam int PROD_W = 2 * Z_W;
    localparam int WIDE_W = PROD_W + 1;
    localparam int DR_W   = WIDE_W - FRAC_BITS;
    localparam int S_W    = DR_W + 1;
    localparam int NUM_W  = HALF_W + IDX_W + 1;
    localparam int SUB_W  = NUM_W + 1;
    localparam int DIG_W     = 14;
    localparam int DIV_STEPS = NUM_W / DIG_W;
    localparam int DIV_X_W   = 26;
    localparam int DIV_M_W   = 27;
    localparam int DIV_P_W   = DIV_X_W + DIV_M_W;
    localparam int DIV_CNT_W = 2;
    localparam int COLOR_IN_W = 18;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd1;

    localparam logic [HALF_W-1:0]  HALF_WIDTH_RST = 31'd536870912;
    localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST = 12'd500;

    localparam logic signed [C_W-1:0]    C_MAX      = {1'b0, {(C_W-1){1'b1}}};
    localparam logic signed [S_W-1:0]    Z_BOUND_HI = 36'sd536870912;
    localparam logic signed [S_W-1:0]    Z_BOUND_LO = -36'sd536870912;
    localparam logic signed [WIDE_W-1:0] MAG_LIMIT  = 63'sd288230376151711744;

    localparam logic [COLOR_IN_W-1:0] RED_K   = 18'd30;
    localparam logic [COLOR_IN_W-1:0] GREEN_K = 18'd40;
    localparam logic [COLOR_IN_W-1:0] BLUE_K  = 18'd50;

    typedef struct packed {
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
    } t_point;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_SUB,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_SQ_R,
        B_SQ_I,
        B_CROSS,
        B_UPDATE,
        B_DONE
    } t_back_state;

    // Residue modulo 255 by folding bytes, since 256 is one more than 255.
    function automatic logic [COLOR_W-1:0] mod255(input logic [COLOR_IN_W-1:0] x);
        logic [10:0] s1;
        logic [8:0]  s2;
        s1 = 11'(x[17:8]) + 11'(x[7:0]);
        s2 = 9'(s1[10:8]) + 9'(s1[7:0]);
        if (s2 >= 9'd255) begin
            s2 = s2 - 9'd255;
        end
        return s2[COLOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/mep_front.sv =====
// Front end: accepts a pixel, maps both indices to the point c with a three-step
// reciprocal divider. Depends on mep_pkg; feeds mep_fifo.
`default_nettype none

module mep_front #(
    parameter int GRID_SIZE = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic [mep_pkg::IDX_W-1:0]  i_pixel_column,
    input  wire logic [mep_pkg::IDX_W-1:0]  i_pixel_row,
    input  wire logic [mep_pkg::HALF_W-1:0] i_half_width,
    output logic                            o_push,
    input  wire logic                       i_full,
    output mep_pkg::t_point                 o_point
);

    localparam int RQ_W     = $clog2(GRID_SIZE);
    localparam int RECIP_SH = mep_pkg::DIV_X_W + RQ_W;
    localparam logic [63:0] RECIP_NUM = 64'd1 << RECIP_SH;
    localparam logic [mep_pkg::DIV_M_W-1:0] RECIP_K =
        mep_pkg::DIV_M_W'((RECIP_NUM + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE));
    localparam logic [mep_pkg::DIV_X_W-1:0] GRID_K = mep_pkg::DIV_X_W'(GRID_SIZE);
    localparam int PRD_W = mep_pkg::NUM_W - 1;

    mep_pkg::t_front_state r_state, n_state;

    logic [mep_pkg::NUM_W-1:0]     r_num [2];
    logic [RQ_W-1:0]               r_rem [2];
    logic [mep_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [mep_pkg::HALF_W-1:0]    r_s;
    mep_pkg::t_point               r_point;

    logic                          accept;
    logic [PRD_W-1:0]              prod_col, prod_row;
    logic [mep_pkg::DIV_X_W-1:0]   dig_x  [2];
    logic [mep_pkg::DIV_P_W-1:0]   dig_p  [2];
    logic [mep_pkg::DIG_W-1:0]     dig_q  [2];
    logic [mep_pkg::DIV_X_W-1:0]   dig_r  [2];
    logic signed [mep_pkg::SUB_W-1:0] diff_c [2];
    logic signed [mep_pkg::C_W-1:0]   c_sat  [2];

    assign accept   = i_start && (r_state == mep_pkg::F_IDLE);
    assign prod_col = PRD_W'(i_half_width) * PRD_W'(i_pixel_column);
    assign prod_row = PRD_W'(i_half_width) * PRD_W'(i_pixel_row);

    // Each step divides the remainder joined with the next digit by the grid size.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            dig_x[k] = mep_pkg::DIV_X_W'({r_rem[k],
                                          r_num[k][mep_pkg::NUM_W-1 -: mep_pkg::DIG_W]});
            dig_p[k] = mep_pkg::DIV_P_W'(dig_x[k]) * mep_pkg::DIV_P_W'(RECIP_K);
            dig_q[k] = dig_p[k][RECIP_SH +: mep_pkg::DIG_W];
            dig_r[k] = dig_x[k] - mep_pkg::DIV_X_W'(dig_q[k]) * GRID_K;
            diff_c[k] = $signed({1'b0, r_num[k]}) -
                        $signed({{(mep_pkg::SUB_W-mep_pkg::HALF_W){1'b0}}, r_s});
            if (diff_c[k] > mep_pkg::SUB_W'(mep_pkg::C_MAX)) begin
                c_sat[k] = mep_pkg::C_MAX;
            end else begin
                c_sat[k] = diff_c[k][mep_pkg::C_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mep_pkg::F_IDLE: begin
                if (i_start) begin
                    n_state = mep_pkg::F_DIV;
                end
            end
            mep_pkg::F_DIV: begin
                if (r_cnt == '0) begin
                    n_state = mep_pkg::F_SUB;
                end
            end
            mep_pkg::F_SUB: begin
                n_state = mep_pkg::F_PUSH;
            end
            mep_pkg::F_PUSH: begin
                if (!i_full) begin
                    n_state = mep_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = mep_pkg::F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy  = (r_state != mep_pkg::F_IDLE);
        o_push  = (r_state == mep_pkg::F_PUSH) && !i_full;
        o_point = r_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mep_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_num[0] <= {prod_col, 1'b0};
            r_num[1] <= {prod_row, 1'b0};
            r_rem[0] <= '0;
            r_rem[1] <= '0;
            r_s      <= i_half_width;
            r_cnt    <= mep_pkg::DIV_CNT_W'(mep_pkg::DIV_STEPS - 1);
        end else if (r_state == mep_pkg::F_DIV) begin
            for (int k = 0; k < 2; k++) begin
                r_num[k] <= {r_num[k][mep_pkg::NUM_W-mep_pkg::DIG_W-1:0], dig_q[k]};
                r_rem[k] <= dig_r[k][RQ_W-1:0];
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (r_state == mep_pkg::F_SUB) begin
            r_point.cr <= c_sat[0];
            r_point.ci <= c_sat[1];
        end
    end

endmodule

`default_nettype wire

// ===== sv/mep_fifo.sv =====
// Two-word queue between the front end and the iteration engine, registered read.
// Depends on mep_pkg.
`default_nettype none

module mep_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mep_pkg::t_point i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output mep_pkg::t_point      o_data
);

    mep_pkg::t_point               r_mem [mep_pkg::FIFO_DEPTH];
    mep_pkg::t_point               r_rd_data;
    logic [mep_pkg::PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [mep_pkg::PTR_W:0]       r_count;

    assign o_full  = (r_count == (mep_pkg::PTR_W+1)'(mep_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/mep_back.sv =====
// Iteration engine: runs z = z*z + c on one shared multiplier and forms the result word.
// Depends on mep_pkg; takes points from mep_fifo.
`default_nettype none

module mep_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [mep_pkg::LIMIT_W-1:0]  i_limit,
    input  wire logic                         i_empty,
    output logic                              o_pop,
    input  wire mep_pkg::t_point              i_point,
    output logic                              o_valid,
    output logic [mep_pkg::LIMIT_W-1:0]       o_escape_count,
    output logic                              o_in_set,
    output logic [mep_pkg::COLOR_W-1:0]       o_red,
    output logic [mep_pkg::COLOR_W-1:0]       o_green,
    output logic [mep_pkg::COLOR_W-1:0]       o_blue
);

    mep_pkg::t_back_state r_state, n_state;

    logic signed [mep_pkg::C_W-1:0]    r_cr, r_ci;
    logic signed [mep_pkg::Z_W-1:0]    r_zr, r_zi;
    logic signed [mep_pkg::PROD_W-1:0] r_rr, r_ii, r_ri;
    logic signed [mep_pkg::DR_W-1:0]   r_dr;
    logic [mep_pkg::LIMIT_W-1:0]       r_iter;
    logic [mep_pkg::LIMIT_W-1:0]       r_count;
    logic                              r_esc;
    logic                              r_valid;
    logic [mep_pkg::LIMIT_W-1:0]       r_out_count;
    logic                              r_out_in_set;
    logic [mep_pkg::COLOR_W-1:0]       r_out_red, r_out_green, r_out_blue;

    logic signed [mep_pkg::Z_W-1:0]    mul_a, mul_b;
    logic signed [mep_pkg::PROD_W-1:0] prod;
    logic signed [mep_pkg::WIDE_W-1:0] mag, diff;
    logic signed [mep_pkg::S_W-1:0]    nr, ni;
    logic                              mag_esc, abs_esc, at_limit;
    logic [mep_pkg::COLOR_IN_W-1:0]    cnt_w;

    assign prod     = mep_pkg::PROD_W'(mul_a) * mep_pkg::PROD_W'(mul_b);
    assign mag      = mep_pkg::WIDE_W'(r_rr) + mep_pkg::WIDE_W'(r_ii);
    assign diff     = mep_pkg::WIDE_W'(r_rr) - mep_pkg::WIDE_W'(r_ii);
    assign mag_esc  = (mag > mep_pkg::MAG_LIMIT) && (r_iter != '0);
    assign at_limit = (r_iter == i_limit);
    assign nr       = mep_pkg::S_W'(r_dr) + mep_pkg::S_W'(r_cr);
    assign ni       = mep_pkg::S_W'($signed(r_ri[mep_pkg::PROD_W-1:mep_pkg::FRAC_BITS-1]))
                    + mep_pkg::S_W'(r_ci);
    assign abs_esc  = (nr > mep_pkg::Z_BOUND_HI) || (nr < mep_pkg::Z_BOUND_LO) ||
                      (ni > mep_pkg::Z_BOUND_HI) || (ni < mep_pkg::Z_BOUND_LO);
    assign cnt_w    = mep_pkg::COLOR_IN_W'(r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mep_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = mep_pkg::B_LOAD;
                end
            end
            mep_pkg::B_LOAD:  n_state = mep_pkg::B_SQ_R;
            mep_pkg::B_SQ_R:  n_state = mep_pkg::B_SQ_I;
            mep_pkg::B_SQ_I:  n_state = mep_pkg::B_CROSS;
            mep_pkg::B_CROSS: begin
                if (mag_esc || at_limit) begin
                    n_state = mep_pkg::B_DONE;
                end else begin
                    n_state = mep_pkg::B_UPDATE;
                end
            end
            mep_pkg::B_UPDATE: begin
                if (abs_esc) begin
                    n_state = mep_pkg::B_DONE;
                end else begin
                    n_state = mep_pkg::B_SQ_R;
                end
            end
            mep_pkg::B_DONE:  n_state = mep_pkg::B_IDLE;
            default:          n_state = mep_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == mep_pkg::B_IDLE) && !i_empty;
        mul_a = (r_state == mep_pkg::B_SQ_I) ? r_zi : r_zr;
        mul_b = (r_state == mep_pkg::B_SQ_R) ? r_zr : r_zi;
        o_valid        = r_valid;
        o_escape_count = r_out_count;
        o_in_set       = r_out_in_set;
        o_red          = r_out_red;
        o_green        = r_out_green;
        o_blue         = r_out_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mep_pkg::B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == mep_pkg::B_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mep_pkg::B_LOAD: begin
                r_cr   <= i_point.cr;
                r_ci   <= i_point.ci;
                r_zr   <= '0;
                r_zi   <= '0;
                r_iter <= '0;
            end
            mep_pkg::B_SQ_R: begin
                r_rr <= prod;
            end
            mep_pkg::B_SQ_I: begin
                r_ii <= prod;
            end
            mep_pkg::B_CROSS: begin
                r_ri <= prod;
                r_dr <= diff[mep_pkg::WIDE_W-1:mep_pkg::FRAC_BITS];
                if (mag_esc) begin
                    r_count <= r_iter - 1'b1;
                    r_esc   <= 1'b1;
                end else if (at_limit) begin
                    r_count <= '0;
                    r_esc   <= 1'b0;
                end
            end
            mep_pkg::B_UPDATE: begin
                r_zr   <= nr[mep_pkg::Z_W-1:0];
                r_zi   <= ni[mep_pkg::Z_W-1:0];
                r_iter <= r_iter + 1'b1;
                if (abs_esc) begin
                    r_count <= r_iter;
                    r_esc   <= 1'b1;
                end
            end
            mep_pkg::B_DONE: begin
                r_out_count  <= r_count;
                r_out_in_set <= !r_esc;
                r_out_red    <= mep_pkg::mod255(cnt_w * mep_pkg::RED_K);
                r_out_green  <= mep_pkg::mod255(cnt_w * mep_pkg::GREEN_K);
                r_out_blue   <= mep_pkg::mod255(cnt_w * mep_pkg::BLUE_K);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/mandelbrot_escape_time_pixel.sv =====
// Top level of the escape-time pixel block: configuration registers and the three parts.
// Depends on mep_pkg, mep_front, mep_fifo and mep_back.
//
// Usage. A pixel word (column, row) is taken at a clock edge where start is high and
// busy is low. Each pixel gives exactly one result word, shown on the o_ result ports
// for a single cycle with o_valid high; the receiver must take it then, it cannot stall.
// The configuration channel (i_cfg_valid, o_cfg_ready, index, data) is always ready and
// should be written only while no pixel is in flight. Index 0 sets the half width of the
// view, index 1 the iteration limit; other indexes are ignored.
// Timing. The front end maps a pixel with its three-step reciprocal divider for the grid
// mapping and takes no new pixel until that one is pushed into the queue, which waits
// while the queue is full. The iteration engine uses one multiplier for three products
// per iteration. A pixel escapes when a component leaves the range of 2.0 or when the
// squared magnitude exceeds four; a pixel that reaches the iteration limit is in the set.
// A two-word queue sits between the parts, so the front end maps the next pixels while
// the engine iterates.
// Reset. Synchronous reset empties the queue, idles both parts and restores a half
// width of 2.0 and an iteration limit of 500.
`default_nettype none

module mandelbrot_escape_time_pixel #(
    parameter int GRID_SIZE = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [mep_pkg::IDX_W-1:0]      i_pixel_column,
    input  wire logic [mep_pkg::IDX_W-1:0]      i_pixel_row,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mep_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mep_pkg::HALF_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    output logic [mep_pkg::LIMIT_W-1:0]         o_escape_count,
    output logic                                o_in_set,
    output logic [mep_pkg::COLOR_W-1:0]         o_red,
    output logic [mep_pkg::COLOR_W-1:0]         o_green,
    output logic [mep_pkg::COLOR_W-1:0]         o_blue
);

    logic [mep_pkg::HALF_W-1:0]  r_half_width;
    logic [mep_pkg::LIMIT_W-1:0] r_limit;

    logic            push, full, pop, empty;
    mep_pkg::t_point front_point, queue_point;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= mep_pkg::HALF_WIDTH_RST;
            r_limit      <= mep_pkg::ITER_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mep_pkg::CFG_HALF_WIDTH: r_half_width <= i_cfg_data;
                mep_pkg::CFG_ITER_LIMIT: r_limit      <= i_cfg_data[mep_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mep_front #(
        .GRID_SIZE(GRID_SIZE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_half_width   (r_half_width),
        .o_push         (push),
        .i_full         (full),
        .o_point        (front_point)
    );

    mep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_point),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (queue_point)
    );

    mep_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_limit        (r_limit),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_point        (queue_point),
        .o_valid        (o_valid),
        .o_escape_count (o_escape_count),
        .o_in_set       (o_in_set),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

endmodule

`default_nettype wire

// ===== sv/mep_checker.sv =====
// Port-level checks of the escape-time pixel block, attached by a bind statement.
// Depends on mep_pkg and on the top level mandelbrot_escape_time_pixel.
`default_nettype none

module mep_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_start,
    input wire logic                          i_busy,
    input wire logic                          i_valid,
    input wire logic [mep_pkg::LIMIT_W-1:0]   i_escape_count,
    input wire logic                          i_in_set,
    input wire logic [mep_pkg::COLOR_W-1:0]   i_red,
    input wire logic [mep_pkg::COLOR_W-1:0]   i_green,
    input wire logic [mep_pkg::COLOR_W-1:0]   i_blue
);

    // A point inside the set always reports a zero count and black.
    a_in_set_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_in_set |-> (i_escape_count == '0) && (i_red == '0) &&
                                (i_green == '0) && (i_blue == '0))
        else $error("in-set result with nonzero count or colour");

    // Results are never shown in two consecutive cycles.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> !i_valid)
        else $error("result strobe held for more than one cycle");

    // An accepted pixel keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !i_busy |=> i_busy)
        else $error("block not busy after accepting a pixel");

    // Reset leaves the block idle with no result showing.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid && !i_busy)
        else $error("block not idle after reset");

endmodule

bind mandelbrot_escape_time_pixel mep_checker u_mep_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (start),
    .i_busy         (busy),
    .i_valid        (o_valid),
    .i_escape_count (o_escape_count),
    .i_in_set       (o_in_set),
    .i_red          (o_red),
    .i_green        (o_green),
    .i_blue         (o_blue)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the escape-time pixel block: directed corner pixels and random views.
// Results are checked against a behavioral escape-time predictor kept in this file.
// Depends on mep_pkg and mandelbrot_escape_time_pixel.
`timescale 1ns / 1ps

module tb;

    localparam int GRID = 1024;

    localparam logic [mep_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [mep_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam longint Q_HI      = 64'sd8589934591;
    localparam longint Q_LO      = -64'sd8589934592;
    localparam longint Z_TWO     = 64'sd536870912;
    localparam longint MAG_FOUR  = 64'sd288230376151711744;

    typedef struct packed {
        logic [mep_pkg::LIMIT_W-1:0] escape_count;
        logic                        in_set;
        logic [mep_pkg::COLOR_W-1:0] red;
        logic [mep_pkg::COLOR_W-1:0] green;
        logic [mep_pkg::COLOR_W-1:0] blue;
    } t_escape_word;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [mep_pkg::IDX_W-1:0]       i_pixel_column = '0;
    logic [mep_pkg::IDX_W-1:0]       i_pixel_row = '0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [mep_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [mep_pkg::HALF_W-1:0]      i_cfg_data = '0;
    logic                            o_valid;
    logic [mep_pkg::LIMIT_W-1:0]     o_escape_count;
    logic                            o_in_set;
    logic [mep_pkg::COLOR_W-1:0]     o_red;
    logic [mep_pkg::COLOR_W-1:0]     o_green;
    logic [mep_pkg::COLOR_W-1:0]     o_blue;

    logic [mep_pkg::HALF_W-1:0]      view_half_width = mep_pkg::HALF_WIDTH_RST;
    logic [mep_pkg::LIMIT_W-1:0]     iteration_limit = mep_pkg::ITER_LIMIT_RST;
    t_escape_word                    pending_escapes[$];
    int                              mismatches = 0;

    mandelbrot_escape_time_pixel #(
        .GRID_SIZE(GRID)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_pixel_column(i_pixel_column),
        .i_pixel_row(i_pixel_row),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_escape_count(o_escape_count),
        .o_in_set(o_in_set),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) begin
            return Q_HI;
        end
        if (v < Q_LO) begin
            return Q_LO;
        end
        return v;
    endfunction

    function automatic longint grid_coord(input logic [mep_pkg::IDX_W-1:0] idx);
        longint unsigned s;
        longint unsigned scaled;
        s = 64'(view_half_width);
        scaled = (64'd2 * s * 64'(idx)) / 64'(GRID);
        return clamp_q(longint'(scaled) - longint'(s));
    endfunction

    function automatic t_escape_word escape_time(input logic [mep_pkg::IDX_W-1:0] col,
                                                 input logic [mep_pkg::IDX_W-1:0] row);
        longint       cr;
        longint       ci;
        longint       zr;
        longint       zi;
        longint       nr;
        longint       ni;
        int unsigned  i;
        int unsigned  count;
        bit           escaped;
        t_escape_word w;
        cr = grid_coord(col);
        ci = grid_coord(row);
        zr = 0;
        zi = 0;
        escaped = 1'b0;
        count = 0;
        for (i = 0; i < iteration_limit && !escaped; i++) begin
            nr = clamp_q(((zr * zr - zi * zi) >>> mep_pkg::FRAC_BITS) + cr);
            ni = clamp_q(((2 * zr * zi) >>> mep_pkg::FRAC_BITS) + ci);
            zr = nr;
            zi = ni;
            if (zr > Z_TWO || zr < -Z_TWO || zi > Z_TWO || zi < -Z_TWO ||
                zr * zr + zi * zi > MAG_FOUR) begin
                escaped = 1'b1;
                count = i;
            end
        end
        if (escaped) begin
            w.escape_count = count[mep_pkg::LIMIT_W-1:0];
            w.in_set = 1'b0;
            w.red = 8'((count * 30) % 255);
            w.green = 8'((count * 40) % 255);
            w.blue = 8'((count * 50) % 255);
        end else begin
            w = '0;
            w.in_set = 1'b1;
        end
        return w;
    endfunction

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_escapes.size() == 0) begin
                $display("%0t ns: result word with none expected, actual count %0d set %0d",
                         $time, o_escape_count, o_in_set);
                mismatches++;
            end else begin
                report_field("escape_count", pending_escapes[0].escape_count, o_escape_count);
                report_field("in_set", pending_escapes[0].in_set, o_in_set);
                report_field("red", pending_escapes[0].red, o_red);
                report_field("green", pending_escapes[0].green, o_green);
                report_field("blue", pending_escapes[0].blue, o_blue);
                void'(pending_escapes.pop_front());
            end
        end
    end

    task automatic send_pixel(input logic [mep_pkg::IDX_W-1:0] col,
                              input logic [mep_pkg::IDX_W-1:0] row);
        start <= 1'b1;
        i_pixel_column <= col;
        i_pixel_row <= row;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_escapes.push_back(escape_time(col, row));
    endtask

    task automatic rest_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_escapes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [mep_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mep_pkg::HALF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            mep_pkg::CFG_HALF_WIDTH: view_half_width = data;
            mep_pkg::CFG_ITER_LIMIT: iteration_limit = data[mep_pkg::LIMIT_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_view();
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(0, 1023);
        send_pixel(1023, 0);
        send_pixel(512, 512);
        send_pixel(256, 512);
        send_pixel(768, 512);
        send_pixel(384, 640);
        send_pixel(0, 512);
        settle();
    endtask

    task automatic test_iteration_limits();
        write_register(mep_pkg::CFG_ITER_LIMIT, 31'h5A5A_A001);
        send_pixel(512, 512);
        send_pixel(0, 0);
        send_pixel(768, 512);
        settle();
        write_register(mep_pkg::CFG_ITER_LIMIT, 31'h7FFF_FFFF);
        send_pixel(512, 512);
        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        settle();
        write_register(mep_pkg::CFG_ITER_LIMIT, 31'h7FFF_F000);
        send_pixel(0, 0);
        send_pixel(512, 512);
        settle();
    endtask

    task automatic test_half_width_extremes();
        write_register(mep_pkg::CFG_ITER_LIMIT, 31'd50);
        write_register(mep_pkg::CFG_HALF_WIDTH, 31'd0);
        send_pixel(0, 0);
        settle();
        write_register(mep_pkg::CFG_HALF_WIDTH, 31'd1);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        settle();
        write_register(mep_pkg::CFG_HALF_WIDTH, 31'h7FFF_FFFF);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(512, 512);
        send_pixel(600, 400);
        settle();
    endtask

    task automatic test_spare_indexes();
        write_register(mep_pkg::CFG_HALF_WIDTH, mep_pkg::HALF_WIDTH_RST);
        write_register(CFG_SPARE_2, 31'($urandom));
        write_register(CFG_SPARE_3, 31'($urandom));
        send_pixel(256, 512);
        send_pixel(768, 512);
        settle();
    endtask

    task automatic run_view_phase(input int items, input bit allow_gaps);
        int                          k;
        logic [mep_pkg::HALF_W-1:0]  hw;
        logic [mep_pkg::LIMIT_W-1:0] lim;
        case ($urandom_range(0, 9))
            0: hw = 31'($urandom_range(1, 32'h7FFF_FFFF));
            1: hw = 31'($urandom_range(1, 32'h0010_0000));
            default: hw = 31'($urandom_range(32'h0800_0000, 32'h3000_0000));
        endcase
        case ($urandom_range(0, 9))
            0: lim = 12'd1;
            1: lim = 12'($urandom_range(64, 96));
            default: lim = 12'($urandom_range(2, 40));
        endcase
        if ($urandom_range(0, 1)) begin
            write_register(mep_pkg::CFG_HALF_WIDTH, hw);
            write_register(mep_pkg::CFG_ITER_LIMIT, {19'($urandom), lim});
        end else begin
            write_register(mep_pkg::CFG_ITER_LIMIT, {19'($urandom), lim});
            write_register(mep_pkg::CFG_HALF_WIDTH, hw);
        end
        for (k = 0; k < items; k++) begin
            if (allow_gaps && $urandom_range(0, 3) == 0) begin
                rest_sender($urandom_range(1, 5));
            end
            send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        settle();
    endtask

    task automatic test_random_views();
        int p;
        for (p = 0; p < 10; p++) begin
            run_view_phase(100, $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_streaming();
        run_view_phase(150, 1'b0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_view();
        test_iteration_limits();
        test_half_width_extremes();
        test_spare_indexes();
        test_random_views();
        test_streaming();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[mandelbrot_escape_time_pixel] OK");
        end else begin
            $display("[mandelbrot_escape_time_pixel] ERROR");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("[mandelbrot_escape_time_pixel] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mep_pkg.sv
sv/mep_front.sv
sv/mep_fifo.sv
sv/mep_back.sv
sv/mandelbrot_escape_time_pixel.sv
sv/mep_checker.sv
sim/tb.sv
